// ===== rtl/core/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg
// Types and constants of the clamped-term PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  // Fixed field widths (gains and terms in Q8.8).
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned TERM_W   = 16;
  localparam int unsigned CORR_W   = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset value of the three limit registers.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN  = 3'd0,
    REG_I_GAIN  = 3'd1,
    REG_D_GAIN  = 3'd2,
    REG_P_LIMIT = 3'd3,
    REG_I_LIMIT = 3'd4,
    REG_D_LIMIT = 3'd5
  } pidc_reg_e;

endpackage : pidc_pkg

`default_nettype wire

// ===== rtl/core/pid_controller_term_clamped.sv =====
// ----------------------------------------------------------------------------
// pid_controller_term_clamped
// PID controller with a symmetric clamp on each of the P, I and D terms and
// anti-windup on the integral; one signed Q8.8 error beat in, one result out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | in        | in_valid_i / in_stall_o | error_i
//  out     | out       | out_valid_o/ out_stall_i| correction_o, p/i/d_term_o
//  cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  An accepted input beat is captured in the input register; the three
//  multipliers, rounding, integral add and clamps run in one pass, and the
//  result register holds the outcome. One beat per cycle is sustained while
//  the output is not stalled; the integral and previous-error state update in
//  the same pass, so consecutive beats chain without bubbles.
//  Reset restores the register defaults (gains 0, limits 32767) and clears
//  the integral and previous error. A stall on the output holds the result
//  register and, once the input register is also full, stalls the input.
//
`default_nettype none

module pid_controller_term_clamped
  import pidc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i,
  // error samples
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0]  error_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [CORR_W-1:0]           correction_o,
  output logic signed [TERM_W-1:0]           p_term_o,
  output logic signed [TERM_W-1:0]           i_term_o,
  output logic signed [TERM_W-1:0]           d_term_o
);

  // Product widths: a 17-bit signed gain times the operand, with headroom for
  // the rounding bias. CW is the common width for the clamp comparisons.
  localparam int unsigned PW  = DATA_WIDTH + GAIN_W + 1;
  localparam int unsigned DPW = DATA_WIDTH + GAIN_W + 2;
  localparam int unsigned CW  = DATA_WIDTH + 10;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]  p_gain_q, i_gain_q, d_gain_q;
  logic [LIMIT_W-1:0] p_limit_q, i_limit_q, d_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q  <= '0;
      i_gain_q  <= '0;
      d_gain_q  <= '0;
      p_limit_q <= LIMIT_RESET;
      i_limit_q <= LIMIT_RESET;
      d_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (pidc_reg_e'(cfg_idx_i))
        REG_P_GAIN:  p_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_I_GAIN:  i_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_D_GAIN:  d_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_P_LIMIT: p_limit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_I_LIMIT: i_limit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_D_LIMIT: d_limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: input register (s1) feeds the result register (s2)
  // --------------------------------------------------------------------------
  logic                          s1_vld_q;
  logic signed [DATA_WIDTH-1:0]  s1_err_q;
  logic                          s2_vld_q;
  logic                          s2_ready;
  logic                          s1_ready;
  logic                          s1_adv;

  assign s2_ready   = !s2_vld_q || !out_stall_i;
  assign s1_ready   = !s1_vld_q || s2_ready;
  assign s1_adv     = s1_vld_q && s2_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_err_q <= error_i;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state: integral stays within +-32767, so 16 bits hold it
  // --------------------------------------------------------------------------
  logic signed [TERM_W-1:0]      acc_q;
  logic signed [DATA_WIDTH-1:0]  prev_q;

  // --------------------------------------------------------------------------
  // Single-pass datapath
  // --------------------------------------------------------------------------
  function automatic logic signed [TERM_W-1:0] clamp_sym(
    input logic signed [CW-1:0] x,
    input logic [LIMIT_W-1:0]   lim
  );
    logic signed [CW-1:0] lim_pos;
    logic signed [CW-1:0] lim_neg;
    lim_pos = $signed({{(CW-LIMIT_W){1'b0}}, lim});
    lim_neg = -lim_pos;
    if (x > lim_pos) begin
      return lim_pos[TERM_W-1:0];
    end else if (x < lim_neg) begin
      return lim_neg[TERM_W-1:0];
    end else begin
      return x[TERM_W-1:0];
    end
  endfunction

  logic signed [PW-1:0]          rnd_bias;
  logic signed [DPW-1:0]         rnd_bias_d;
  logic signed [PW-1:0]          p_prod, i_prod;
  logic signed [DPW-1:0]         d_prod;
  logic signed [PW-1:0]          p_biased, i_biased;
  logic signed [DPW-1:0]         d_biased;
  logic signed [DATA_WIDTH:0]    err_diff;
  logic signed [CW-1:0]          p_wide, i_wide, d_wide;
  logic signed [TERM_W-1:0]      p_clamped, i_clamped, d_clamped;
  logic signed [CORR_W-1:0]      corr_sum;

  assign rnd_bias   = $signed({{(PW-8){1'b0}}, 8'h80});
  assign rnd_bias_d = $signed({{(DPW-8){1'b0}}, 8'h80});

  // Difference one bit wider so an extreme step never wraps.
  assign err_diff = $signed({s1_err_q[DATA_WIDTH-1], s1_err_q})
                  - $signed({prev_q[DATA_WIDTH-1], prev_q});

  assign p_prod = $signed({1'b0, p_gain_q}) * s1_err_q;
  assign i_prod = $signed({1'b0, i_gain_q}) * s1_err_q;
  assign d_prod = $signed({1'b0, d_gain_q}) * err_diff;

  // Round Q16.16 to Q8.8: add half an LSB, then floor by dropping 8 bits.
  assign p_biased = p_prod + rnd_bias;
  assign i_biased = i_prod + rnd_bias;
  assign d_biased = d_prod + rnd_bias_d;

  // Keep the sign when widening the rounded products.
  assign p_wide = CW'($signed(p_biased[PW-1:8]));
  assign d_wide = CW'($signed(d_biased[DPW-1:8]));
  assign i_wide = CW'($signed(i_biased[PW-1:8])) + CW'(acc_q);

  assign p_clamped = clamp_sym(p_wide, p_limit_q);
  assign i_clamped = clamp_sym(i_wide, i_limit_q);
  assign d_clamped = clamp_sym(d_wide, d_limit_q);

  assign corr_sum = CORR_W'(p_clamped) + CORR_W'(i_clamped) + CORR_W'(d_clamped);

  // Advance state together with the result so they always agree.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      prev_q <= '0;
    end else if (s1_adv) begin
      acc_q  <= i_clamped;
      prev_q <= s1_err_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic signed [CORR_W-1:0] corr_q;
  logic signed [TERM_W-1:0] p_q, i_q, d_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      corr_q <= corr_sum;
      p_q    <= p_clamped;
      i_q    <= i_clamped;
      d_q    <= d_clamped;
    end
  end

  assign out_valid_o  = s2_vld_q;
  assign correction_o = corr_q;
  assign p_term_o     = p_q;
  assign i_term_o     = i_q;
  assign d_term_o     = d_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_corr_is_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (corr_q == CORR_W'(p_q) + CORR_W'(i_q) + CORR_W'(d_q)))
    else $error("correction differs from sum of terms");

  a_acc_matches_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (acc_q == i_q))
    else $error("integral state out of step with result");

  a_acc_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q != $signed({1'b1, {(TERM_W-1){1'b0}}}))
    else $error("integral left the clamp range");

  a_p_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> ((CW'(p_q) <= $signed({{(CW-LIMIT_W){1'b0}}, p_limit_q}))
               && (CW'(p_q) >= -$signed({{(CW-LIMIT_W){1'b0}}, p_limit_q}))))
    else $error("P term beyond its limit");

endmodule : pid_controller_term_clamped

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clamped-term PID controller. A directed table
// covers reset defaults, full-scale errors and gains, zero limits, rounding of
// halves, ignored register indexes and a lowered integral limit. Random phases
// with fresh register settings follow. Every result beat is compared field by
// field against a hand-written table result or a bit-accurate Q8.8 bench model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pidc_pkg::*;

  localparam int unsigned DW          = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_BEATS = 80;

  // Indexes outside the register map; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [CORR_W-1:0] corr;
    logic signed [TERM_W-1:0] p;
    logic signed [TERM_W-1:0] i;
    logic signed [TERM_W-1:0] d;
  } pid_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [DW-1:0]    err;
    logic                    typed;  // use the hand-written result below
    pid_result_t             res;
  } dir_row_t;

  localparam pid_result_t RES_ZERO = '0;
  localparam pid_result_t RES_POS_SAT =
    '{18'sd98301, 16'sd32767, 16'sd32767, 16'sd32767};
  localparam pid_result_t RES_NEG_SAT =
    '{-18'sd98301, -16'sd32767, -16'sd32767, -16'sd32767};
  localparam pid_result_t RES_I_LOW_D_HIGH =
    '{18'sd0, 16'sd0, -16'sd32767, 16'sd32767};

  // Directed walk: register writes and samples, in order.
  localparam dir_row_t DIR_TBL [32] = '{
    // reset gains are zero: every term is zero at full-scale errors
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh7FFF, 1'b1, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh8000, 1'b1, RES_ZERO},
    // maximum gains: every term saturates, including the widest error step
    '{ROW_WRITE,  REG_P_GAIN,  16'hFFFF, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_I_GAIN,  16'hFFFF, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_D_GAIN,  16'hFFFF, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh7FFF, 1'b1, RES_POS_SAT},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh8000, 1'b1, RES_NEG_SAT},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh0000, 1'b1, RES_I_LOW_D_HIGH},
    // zero limits force every term to zero
    '{ROW_WRITE,  REG_P_LIMIT, 16'h0000, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_I_LIMIT, 16'h0000, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_D_LIMIT, 16'h0000, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh04D2, 1'b1, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh8000, 1'b1, RES_ZERO},
    // top data bit of a limit write is dropped
    '{ROW_WRITE,  REG_P_LIMIT, 16'hFFFF, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_I_LIMIT, 16'h7FFF, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_D_LIMIT, 16'h7FFF, 16'sh0000, 1'b0, RES_ZERO},
    // gains of one half: halves round toward plus infinity
    '{ROW_WRITE,  REG_P_GAIN,  16'h0080, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_I_GAIN,  16'h0080, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_D_GAIN,  16'h0080, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh0001, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'shFFFF, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'shFFFD, 1'b0, RES_ZERO},
    // writes outside the map must leave the gains alone
    '{ROW_WRITE,  REG_SPARE_6, 16'h0000, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_SPARE_7, 16'h0000, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh012C, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh0258, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh0384, 1'b0, RES_ZERO},
    // integral limit lowered while the accumulator sits above it
    '{ROW_WRITE,  REG_I_LIMIT, 16'h0064, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh0005, 1'b0, RES_ZERO},
    // zero integral gain: accumulator holds its value
    '{ROW_WRITE,  REG_I_GAIN,  16'h0000, 16'sh0000, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'sh0032, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, REG_P_GAIN,  16'h0000, 16'shFD44, 1'b0, RES_ZERO}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_idx_i;
  logic [CFG_DATA_W-1:0]       cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [DW-1:0]        error_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [CORR_W-1:0]    correction_o;
  logic signed [TERM_W-1:0]    p_term_o;
  logic signed [TERM_W-1:0]    i_term_o;
  logic signed [TERM_W-1:0]    d_term_o;

  pid_controller_term_clamped #(
    .DATA_WIDTH(DW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .error_i      (error_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .correction_o (correction_o),
    .p_term_o     (p_term_o),
    .i_term_o     (i_term_o),
    .d_term_o     (d_term_o)
  );

  // Bench copy of the controller registers and state.
  logic [GAIN_W-1:0]  kp, ki, kd;
  logic [LIMIT_W-1:0] lim_p, lim_i, lim_d;
  longint             integ_acc;
  longint             prev_err;

  pid_result_t        pid_expect_q [$];
  int unsigned        mismatch_cnt;
  int unsigned        cycle_cnt;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  logic               long_hold;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Exact Q16.16 product rounded back to Q8.8, halves toward plus infinity.
  function automatic longint q88_scale(input logic [GAIN_W-1:0] gain, input longint v);
    return (longint'(gain) * v + 128) >>> 8;
  endfunction

  function automatic longint clamp_term(input longint x, input logic [LIMIT_W-1:0] lim);
    longint l;
    l = longint'(lim);
    if (x > l) return l;
    if (x < -l) return -l;
    return x;
  endfunction

  // One control tick: compute the three clamped terms and advance the state.
  function automatic pid_result_t pid_update(input logic signed [DW-1:0] err);
    longint      e, p, i, d, sum;
    pid_result_t r;
    e   = longint'(err);
    p   = clamp_term(q88_scale(kp, e), lim_p);
    i   = clamp_term(integ_acc + q88_scale(ki, e), lim_i);
    d   = clamp_term(q88_scale(kd, e - prev_err), lim_d);
    sum = p + i + d;
    integ_acc = i;
    prev_err  = e;
    r.corr = sum[CORR_W-1:0];
    r.p    = p[TERM_W-1:0];
    r.i    = i[TERM_W-1:0];
    r.d    = d[TERM_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Offer one error beat, with random idle cycles ahead of it. Valid is left
  // high on return; the caller either offers the next beat or drops it.
  task automatic send_error(input logic signed [DW-1:0] err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      error_i    <= DW'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    error_i    <= err;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Register write, only once every outstanding result has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (pid_expect_q.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_P_GAIN:  kp    = data;
      REG_I_GAIN:  ki    = data;
      REG_D_GAIN:  kd    = data;
      REG_P_LIMIT: lim_p = data[LIMIT_W-1:0];
      REG_I_LIMIT: lim_i = data[LIMIT_W-1:0];
      REG_D_LIMIT: lim_d = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1:       return 16'($urandom_range(1023));
      default: return 16'($urandom);
    endcase
  endfunction

  // Limits carry a random top bit, which the block must drop.
  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    logic top;
    top = 1'($urandom);
    case ($urandom_range(3))
      0:       return {top, $urandom_range(1) ? 15'h7FFF : 15'h0000};
      1:       return {top, 15'($urandom_range(2000))};
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: check each accepted beat, then pick next cycle's stall.
  always @(posedge clk_i) begin : watch_results
    pid_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pid_expect_q.size() == 0) begin
        report_mismatch("unexpected result beat", correction_o, 0);
      end else begin
        want = pid_expect_q.pop_front();
        if (correction_o !== want.corr) report_mismatch("correction", correction_o, want.corr);
        if (p_term_o !== want.p) report_mismatch("p_term", p_term_o, want.p);
        if (i_term_o !== want.i) report_mismatch("i_term", i_term_o, want.i);
        if (d_term_o !== want.d) report_mismatch("d_term", d_term_o, want.d);
      end
    end
    out_stall_i <= long_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] v;
    logic signed [DW-1:0]  e;
    logic signed [DW-1:0]  last_err;
    int                    step;
    pid_result_t           r;

    // Hold every input at a known value from time zero.
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    error_i       = '0;
    out_stall_i   = 1'b0;
    long_hold     = 1'b0;
    recv_idle_pct = 0;
    send_idle_pct = 0;
    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    last_err      = '0;

    kp        = '0;
    ki        = '0;
    kd        = '0;
    lim_p     = LIMIT_RESET;
    lim_i     = LIMIT_RESET;
    lim_d     = LIMIT_RESET;
    integ_acc = 0;
    prev_err  = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, with the sender lightly and the receiver heavily idle.
    send_idle_pct = 12;
    recv_idle_pct <= 69;
    @(posedge clk_i);
    foreach (DIR_TBL[n]) begin
      if (DIR_TBL[n].kind == ROW_WRITE) begin
        write_reg(DIR_TBL[n].idx, DIR_TBL[n].data);
      end else begin
        send_error(DIR_TBL[n].err);
        r = pid_update(DIR_TBL[n].err);
        pid_expect_q.push_back(DIR_TBL[n].typed ? DIR_TBL[n].res : r);
      end
    end

    // Random phases: new register settings, then a run of error samples.
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int ri = 0; ri < 6; ri++) begin
        if (ph == 0) v = 16'hFFFF;
        else if (ph == 1 && ri >= int'(REG_P_LIMIT)) v = '0;
        else v = (ri < int'(REG_P_LIMIT)) ? pick_gain() : pick_limit();
        write_reg(ri[CFG_IDX_W-1:0], v);
      end
      if ($urandom_range(2) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));

      // Swap idle profiles by phase group; the last group runs flat out.
      if (ph < 4) begin
        send_idle_pct = 12;
        recv_idle_pct <= 69;
      end else if (ph < 8) begin
        send_idle_pct = 69;
        recv_idle_pct <= 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end

      // Hold off the receiver for a long stretch so the block backs up.
      if (ph == 8) begin
        fork
          begin
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            long_hold <= 1'b0;
          end
        join_none
      end

      for (int k = 0; k < PHASE_BEATS; k++) begin
        // A mix of full-scale errors, random jumps, small drifts and small values.
        case ($urandom_range(7))
          0: e = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          1, 2: e = DW'($urandom);
          3, 4: begin
            step = int'($urandom_range(64)) - 32;
            e = last_err + DW'(step);
          end
          default: begin
            step = int'($urandom_range(512)) - 256;
            e = DW'(step);
          end
        endcase
        last_err = e;
        send_error(e);
        pid_expect_q.push_back(pid_update(e));
      end
    end

    // Drain: drop valid and wait for the last result before reporting.
    in_valid_i <= 1'b0;
    while (pid_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule : tb_top

`default_nettype wire
